FILE: sv/pvm_pkg.sv
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types and constants of the PCM voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

	localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_PLAY = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAY,
		ST_TICK,
		ST_TICK_LAST,
		ST_DONE
	} state_t;

	// control of the shared saturating accumulator
	typedef struct packed {
		logic clear;
		logic add;
	} acc_ctrl_t;

endpackage

FILE: sv/pvm_ram.sv
// ----------------------------------------------------------------------------
// pvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pvm_sat_acc.sv
// ----------------------------------------------------------------------------
// pvm_sat_acc
// Shared 16-bit accumulator that saturates after every add.
// ----------------------------------------------------------------------------
module pvm_sat_acc (
	input  logic                     clk,
	input  pvm_pkg::acc_ctrl_t       ctrl,
	input  logic signed [15:0]       sample,
	output logic signed [15:0]       sum
);

	logic signed [15:0] sum_q;
	logic signed [16:0] wide;
	logic signed [15:0] sat;

	always_comb begin
		wide = {sum_q[15], sum_q} + {sample[15], sample};
		if (wide[16] != wide[15]) begin
			// overflow: clamp toward the sign of the true sum
			sat = wide[16] ? pvm_pkg::PCM_MIN : pvm_pkg::PCM_MAX;
		end else begin
			sat = wide[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.add) begin
			sum_q <= sat;
		end
	end

	assign sum = sum_q;

endmodule

FILE: sv/pcm_voice_mixer.sv
// ----------------------------------------------------------------------------
// pcm_voice_mixer
// Multi-voice saturating PCM mixer over one sample memory.
// ----------------------------------------------------------------------------
// Load: written to the sample memory at the transfer.
// Play: the voice scan looks for the lowest free voice.
// Tick: one voice a cycle through the sample memory read
//   port and the shared saturating adder, then ST_TICK_LAST drains the last read.
// Results leave through an output register; one item is in work at a time.
// Reset clears voice state and handshakes; sample memory is not cleared.
module pcm_voice_mixer #(
	parameter int VOICE_COUNT  = 8,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sample_address[15:0], sample_value[31:16], sound_start[47:32],
	// sound_length[64:48], zero pad [71:65]
	input  logic [71:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mixed_sample[15:0], play_accepted[16], voice_index[19:17], busy_voices[23:20]
	output logic [23:0] m_tdata
);

	localparam int ADDR_W = $clog2(SAMPLE_WORDS);
	localparam int VW     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CW     = $clog2(VOICE_COUNT + 1);

	// 16-bit value modulo SAMPLE_WORDS, exact while the quotient fits in 8 bits
	function automatic logic [ADDR_W-1:0] mod_words(input logic [15:0] x);
		logic [31:0] r;
		r = 32'(x);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (32'(SAMPLE_WORDS) << k)) begin
				r = r - (32'(SAMPLE_WORDS) << k);
			end
		end
		return ADDR_W'(r);
	endfunction

	pvm_pkg::state_t    state_q, state_d;
	pvm_pkg::op_t       in_op;
	pvm_pkg::acc_ctrl_t acc_ctrl;

	logic              accept;
	logic [VW-1:0]     v_q;
	logic              v_last;
	logic [CW-1:0]     cnt_q;
	logic              pend_q;
	logic              ok_q;
	logic [2:0]        idx_q;
	logic [ADDR_W-1:0] start_q;
	logic [16:0]       length_q;

	logic              busy_q   [VOICE_COUNT];
	logic [ADDR_W-1:0] cursor_q [VOICE_COUNT];
	logic [16:0]       rem_q    [VOICE_COUNT];

	logic              claim, tick_step, v_inc, out_load, out_free;
	logic              cur_busy, cur_live, cur_end;
	logic [ADDR_W-1:0] cur_addr;
	logic [16:0]       cur_rem;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_rdata;
	logic signed [15:0] acc_sum;

	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;

	assign in_op    = pvm_pkg::op_t'(s_tuser);
	assign s_tready = (state_q == pvm_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign v_last   = (v_q == VW'(VOICE_COUNT - 1));
	assign out_free = !m_tvalid_q || m_tready;

	assign cur_busy = busy_q[v_q];
	assign cur_rem  = rem_q[v_q];
	assign cur_addr = cursor_q[v_q];
	assign cur_live = cur_busy && (cur_rem != '0);
	// voice frees now: empty on entry, or its last sample is read now
	assign cur_end  = cur_busy && ((cur_rem == '0) || (cur_rem == 17'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		claim     = 1'b0;
		tick_step = 1'b0;
		v_inc     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			pvm_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_op)
						pvm_pkg::OP_PLAY: state_d = pvm_pkg::ST_PLAY;
						pvm_pkg::OP_TICK: state_d = pvm_pkg::ST_TICK;
						default:          state_d = pvm_pkg::ST_IDLE;
					endcase
				end
			end
			pvm_pkg::ST_PLAY: begin
				if (!cur_busy) begin
					claim   = 1'b1;
					state_d = pvm_pkg::ST_DONE;
				end else if (v_last) begin
					state_d = pvm_pkg::ST_DONE;
				end else begin
					v_inc = 1'b1;
				end
			end
			pvm_pkg::ST_TICK: begin
				tick_step = 1'b1;
				if (v_last) begin
					state_d = pvm_pkg::ST_TICK_LAST;
				end else begin
					v_inc = 1'b1;
				end
			end
			pvm_pkg::ST_TICK_LAST: begin
				state_d = pvm_pkg::ST_DONE;
			end
			pvm_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pvm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pvm_pkg::ST_IDLE;
			end
		endcase
	end

	// accumulate the word read for the previous voice
	assign acc_ctrl.clear = accept && ((in_op == pvm_pkg::OP_PLAY) ||
	                                   (in_op == pvm_pkg::OP_TICK));
	assign acc_ctrl.add   = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
			ok_q   <= 1'b0;
			idx_q  <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				busy_q[i] <= 1'b0;
			end
		end else begin
			pend_q <= tick_step && cur_live;
			if (accept) begin
				v_q   <= '0;
				ok_q  <= 1'b0;
				idx_q <= '0;
			end else if (v_inc) begin
				v_q <= v_q + 1'b1;
			end
			if (claim) begin
				busy_q[v_q] <= 1'b1;
				cnt_q       <= cnt_q + 1'b1;
				ok_q        <= 1'b1;
				idx_q       <= 3'(v_q);
			end else if (tick_step && cur_end) begin
				busy_q[v_q] <= 1'b0;
				cnt_q       <= cnt_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q  <= mod_words(s_tdata[47:32]);
			length_q <= s_tdata[64:48];
		end
		if (claim) begin
			cursor_q[v_q] <= start_q;
			rem_q[v_q]    <= length_q;
		end else if (tick_step && cur_live) begin
			cursor_q[v_q] <= (cur_addr == ADDR_W'(SAMPLE_WORDS - 1)) ? '0 : cur_addr + 1'b1;
			rem_q[v_q]    <= cur_rem - 1'b1;
		end
	end

	assign ram_we    = accept && (in_op == pvm_pkg::OP_LOAD);
	assign ram_waddr = mod_words(s_tdata[15:0]);

	pvm_ram #(
		.WIDTH(16),
		.DEPTH(SAMPLE_WORDS)
	) u_sample_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata[31:16]),
		.re    (tick_step && cur_live),
		.raddr (cur_addr),
		.rdata (ram_rdata)
	);

	pvm_sat_acc u_acc (
		.clk    (clk),
		.ctrl   (acc_ctrl),
		.sample (signed'(ram_rdata)),
		.sum    (acc_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'(cnt_q), idx_q, ok_q, acc_sum};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: sv/pvm_checker.sv
// ----------------------------------------------------------------------------
// pvm_checker
// Port-level checks of the PCM voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
module pvm_checker #(
	parameter int VOICE_COUNT = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// hold a stalled result transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (VOICE_COUNT >= 15) || (m_tdata[23:20] <= 4'(VOICE_COUNT)))
		else $error("busy voice count out of range");

	a_reject_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[16] |-> (m_tdata[19:17] == 3'd0))
		else $error("voice index set without a granted play");

	// a count of sixteen or more wraps in the 4-bit field
	a_play_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> (m_tdata[15:0] == 16'd0) &&
			((VOICE_COUNT >= 16) || (m_tdata[23:20] != 4'd0)))
		else $error("granted play shows a sample or no busy voice");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid || $past(m_tvalid) || !s_tready)
		else $error("result appeared in the transfer cycle");

endmodule

bind pcm_voice_mixer pvm_checker #(
	.VOICE_COUNT(VOICE_COUNT)
) u_pvm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
